### rtl/pif_pkg.sv
// Package for the padded integer formatter: item type, kind codes, ASCII constants
// and the small helper functions shared by the conversion cells and the serializer.
// No dependencies.
package pif_pkg;

  localparam int VALUE_W       = 32;          // bits of the argument
  localparam int NDIG          = 10;          // decimal digits of a 32-bit magnitude
  localparam int BCD_W         = NDIG * 4;    // digit register width
  localparam int KIND_W        = 2;
  localparam int WIDTH_W       = 6;
  localparam int CHAR_W        = 8;
  localparam int TXT_CNT_W     = 4;           // text is at most sign plus ten digits
  localparam int MAX_WIDTH_DEF = 32;

  // Conversion kinds
  localparam logic [KIND_W-1:0] KIND_DEC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // ASCII
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_HEX_GAP = 8'd7;   // distance from ':' to 'A'

  // One request on its way through the conversion row
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               neg;     // decimal value was negative
    logic [WIDTH_W-1:0] width;
    logic               zpad;
    logic               left;
    logic [VALUE_W-1:0] bin;     // magnitude bits still to be shifted in, MSB first
    logic [BCD_W-1:0]   bcd;     // digits collected so far
  } pif_item_t;

  // Map one digit (0..15) to its uppercase ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    c = CH_ZERO + {4'd0, d};
    if (c > CH_NINE) c = c + CH_HEX_GAP;
    return c;
  endfunction

  // Add three to every BCD digit of five or more before the next shift
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < NDIG; i++) begin
      if (b[4*i +: 4] >= 4'd5) r[4*i +: 4] = b[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

endpackage

### rtl/pif_cell.sv
// One conversion cell: shifts one magnitude bit into the digit register,
// with BCD correction for decimal requests. Depends on pif_pkg.
module pif_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  pif_pkg::pif_item_t  in_item,
  output logic                out_vld,
  output pif_pkg::pif_item_t  out_item
);
  import pif_pkg::*;

  logic             vld_r;
  pif_item_t        item_r;
  pif_item_t        item_nxt;
  logic [BCD_W-1:0] adj;

  // Correct digits for decimal, then shift in the next magnitude bit
  always_comb begin
    adj               = (in_item.kind == KIND_DEC) ? dabble_adjust(in_item.bcd) : in_item.bcd;
    item_nxt          = in_item;
    item_nxt.bcd      = {adj[BCD_W-2:0], in_item.bin[VALUE_W-1]};
    item_nxt.bin      = {in_item.bin[VALUE_W-2:0], 1'b0};
  end

  // Advance the whole row together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

### rtl/pif_ser.sv
// Serializer: strips leading zeros, sizes the padding and sends the field through a
// registered output stage, one character per cycle while ready. Depends on pif_pkg.
module pif_ser #(
  parameter int MAX_WIDTH = pif_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        src_vld,
  input  pif_pkg::pif_item_t          src_item,
  output logic                        src_take,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pif_pkg::CHAR_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  import pif_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  logic [CNT_W-1:0]     pad_cnt_r;
  logic [TXT_CNT_W-1:0] txt_cnt_r;
  logic                 neg_r;
  logic                 left_r;
  logic                 chr_r;
  logic [CHAR_W-1:0]    padc_r;
  logic [BCD_W-1:0]     dig_r;
  logic                 out_tvalid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [CNT_W:0]       remain;
  logic                 busy, out_adv, emit, load, in_text;
  logic [CHAR_W-1:0]    emit_char;
  logic [3:0]           hi;
  logic [TXT_CNT_W-1:0] ld_txt;
  logic [CNT_W-1:0]     ld_len, ld_wsat, ld_pad;
  logic [BCD_W-1:0]     ld_dig;

  // Handshake between the row, the counters and the output stage
  always_comb begin
    remain   = {1'b0, pad_cnt_r} + (CNT_W+1)'(txt_cnt_r);
    busy     = (remain != '0);
    out_adv  = !out_tvalid_r || out_tready;
    emit     = busy && out_adv;
    src_take = !busy || ((remain == (CNT_W+1)'(1)) && out_adv);
    load     = src_take && src_vld;
  end

  // Size the text and left-align its first significant digit
  always_comb begin
    hi = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (src_item.bcd[4*i +: 4] != 4'd0) hi = 4'(i);
    end
    if (src_item.kind == KIND_CHR) begin
      ld_txt = TXT_CNT_W'(1);
      ld_dig = {src_item.bcd[CHAR_W-1:0], {(BCD_W-CHAR_W){1'b0}}};
    end else begin
      ld_txt = hi + 4'd1 + {3'd0, src_item.neg};
      ld_dig = src_item.bcd << {(4'(NDIG-1) - hi), 2'b00};
    end
    if (src_item.kind == KIND_NONE) ld_txt = '0;
    ld_len = CNT_W'(ld_txt);
    if (32'(src_item.width) > 32'(MAX_WIDTH)) ld_wsat = CNT_W'(MAX_WIDTH);
    else ld_wsat = CNT_W'(src_item.width);
    ld_pad = (ld_wsat > ld_len && src_item.kind != KIND_NONE) ? ld_wsat - ld_len : '0;
  end

  // Pick the next character: padding or text, depending on justification
  always_comb begin
    in_text = left_r ? (txt_cnt_r != '0) : (pad_cnt_r == '0);
    if (!in_text)   emit_char = padc_r;
    else if (chr_r) emit_char = dig_r[BCD_W-1 -: CHAR_W];
    else if (neg_r) emit_char = CH_MINUS;
    else            emit_char = digit_char(dig_r[BCD_W-1 -: 4]);
  end

  // Load a new request or count down the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_cnt_r <= '0;
      txt_cnt_r <= '0;
      neg_r     <= 1'b0;
    end else if (load) begin
      pad_cnt_r <= ld_pad;
      txt_cnt_r <= ld_txt;
      neg_r     <= src_item.neg;
    end else if (emit) begin
      if (in_text) begin
        txt_cnt_r <= txt_cnt_r - TXT_CNT_W'(1);
        neg_r     <= 1'b0;
      end else begin
        pad_cnt_r <= pad_cnt_r - CNT_W'(1);
      end
    end
  end

  // Text payload: shift out one digit after each digit sent
  always_ff @(posedge clk) begin
    if (load) begin
      dig_r  <= ld_dig;
      left_r <= src_item.left;
      chr_r  <= (src_item.kind == KIND_CHR);
      padc_r <= (src_item.zpad && !src_item.left) ? CH_ZERO : CH_SPACE;
    end else if (emit && in_text && !neg_r && !chr_r) begin
      dig_r  <= {dig_r[BCD_W-5:0], 4'd0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_adv) begin
      out_tvalid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= (remain == (CNT_W+1)'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // A pending sign is always followed by at least one digit
  a_sign_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    neg_r |-> (txt_cnt_r >= TXT_CNT_W'(2)))
    else $error("sign pending without a digit behind it");

  // Text never exceeds sign plus all digits
  a_txt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    txt_cnt_r <= TXT_CNT_W'(NDIG + 1))
    else $error("text count out of range");

  // A field never runs past the widest allowed field or its text
  a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pad_cnt_r) + 32'(txt_cnt_r) <= 32'(MAX_WIDTH)) || (pad_cnt_r == '0))
    else $error("field longer than the maximum width");

  // A request is never taken while the current field has more than one character left
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (remain <= (CNT_W+1)'(1)))
    else $error("new request loaded over an unfinished field");

endmodule

### rtl/padded_integer_formatter_top.sv
// Top level of the padded integer formatter: entry logic, the row of conversion
// cells and the serializer. Depends on pif_pkg, pif_cell and pif_ser.
//
// Each request (signed decimal, uppercase hex or one character, with field width,
// zero-pad and left-justify flags) becomes a stream of ASCII characters, one per
// cycle while the receiver is ready, with tlast on the final one. The value passes a
// row of 32 conversion cells, one magnitude bit per cell, before the serializer.
// A field holds max(text length, width) characters, with width capped at MAX_WIDTH:
// 1 to 11 for unpadded text and up to MAX_WIDTH (32 by default) for a full field.
// A request of kind 3 produces nothing. Requests stream in back to back and wait
// in the cell row while a field is sent.
module padded_integer_formatter_top #(
  parameter int MAX_WIDTH = pif_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: value[31:0], width[37:32], zero_pad[38], left_justify[39]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,
  // in_tuser: kind[1:0]
  input  logic [pif_pkg::KIND_W-1:0]    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: out_char[7:0]
  output logic [pif_pkg::CHAR_W-1:0]    out_tdata,
  output logic                          out_tlast
);
  import pif_pkg::*;

  logic               vld   [0:VALUE_W];
  pif_item_t          item  [0:VALUE_W];
  logic               adv;
  logic               take;
  logic [VALUE_W-1:0] value;
  logic               neg;

  // Unpack the request and take the magnitude of a negative decimal value
  always_comb begin
    value           = in_tdata[VALUE_W-1:0];
    neg             = (in_tuser == KIND_DEC) && value[VALUE_W-1];
    item[0].kind    = in_tuser;
    item[0].neg     = neg;
    item[0].width   = in_tdata[VALUE_W +: WIDTH_W];
    item[0].zpad    = in_tdata[VALUE_W + WIDTH_W];
    item[0].left    = in_tdata[VALUE_W + WIDTH_W + 1];
    item[0].bin     = neg ? (~value + VALUE_W'(1)) : value;
    item[0].bcd     = '0;
    vld[0]          = in_tvalid;
  end

  // Advance the row when its last cell is empty or the serializer takes it
  assign adv       = !vld[VALUE_W] || take;
  assign in_tready = adv;

  // Row of conversion cells
  for (genvar g = 0; g < VALUE_W; g++) begin : g_cell
    pif_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld[g]),
      .in_item  (item[g]),
      .out_vld  (vld[g+1]),
      .out_item (item[g+1])
    );
  end

  pif_ser #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_vld    (vld[VALUE_W]),
    .src_item   (item[VALUE_W]),
    .src_take   (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### tb/padded_integer_formatter_top_tb.sv
// Testbench for padded_integer_formatter_top: drives conversion requests, predicts the
// character stream of each field and checks every character and its tlast marker.
// Depends on pif_pkg and the RTL of the formatter.
`timescale 1ns / 1ps

module padded_integer_formatter_top_tb;
  import pif_pkg::*;

  localparam int MAX_FIELD    = 32;      // field width cap of the default build
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;     // covers the trip through the cell row and the serializer plus margin
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 38;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } fmt_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata = '0;
  logic [KIND_W-1:0]    in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CHAR_W-1:0]    out_tdata;
  logic                 out_tlast;

  fmt_char_t exp_chars[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  logic      no_idle = 1'b0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_cnt = 0;

  padded_integer_formatter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Work out the characters of one field and queue them
  function automatic void predict_field(input logic [KIND_W-1:0] kind,
                                        input logic [31:0] value,
                                        input logic [WIDTH_W-1:0] width,
                                        input logic zpad, input logic left);
    logic [CHAR_W-1:0] txt [0:11];
    logic [CHAR_W-1:0] digs [0:11];
    logic [31:0]       mag;
    logic [3:0]        d;
    logic [CHAR_W-1:0] padc;
    int                len, nd, fw, pad, total;
    fmt_char_t         c;
    len = 0;
    nd = 0;
    if (kind == KIND_NONE) return;
    fw = (width > MAX_FIELD) ? MAX_FIELD : int'(width);
    if (kind == KIND_CHR) begin
      txt[0] = value[7:0];
      len = 1;
    end else begin
      mag = value;
      if (kind == KIND_DEC && value[31]) begin
        txt[0] = CH_MINUS;
        len = 1;
        mag = 32'd0 - value;
      end
      // collect digits least significant first
      do begin
        if (kind == KIND_DEC) begin
          d = 4'(mag % 32'd10);
          mag = mag / 32'd10;
        end else begin
          d = mag[3:0];
          mag = mag >> 4;
        end
        digs[nd] = (d < 4'd10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d) - 8'd10;
        nd++;
      end while (mag != 0);
      while (nd > 0) begin
        nd--;
        txt[len] = digs[nd];
        len++;
      end
    end
    pad = (fw > len) ? fw - len : 0;
    total = len + pad;
    padc = (zpad && !left) ? CH_ZERO : CH_SPACE;
    for (int i = 0; i < total; i++) begin
      if (!left) c.ch = (i < pad) ? padc : txt[i - pad];
      else c.ch = (i < len) ? txt[i] : CH_SPACE;
      c.last = (i == total - 1);
      exp_chars.push_back(c);
    end
  endfunction

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [31:0] value,
                          input logic [WIDTH_W-1:0] width, input logic zpad,
                          input logic left);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {left, zpad, width, value};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_field(kind, value, width, zpad, left);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = 1;
      while ($urandom_range(0, 99) < IDLE_PCT && gap < 6) gap++;
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower valid after the last request of a burst
  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 20));
      1: return 32'd0 - 32'($urandom_range(1, 20));
      2: return 32'h8000_0000 ^ 32'($urandom_range(0, 3));
      3: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      4: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    if ($urandom_range(0, 9) < 8) return WIDTH_W'($urandom_range(0, 12));
    return WIDTH_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return KIND_DEC;
    if (r < 80) return KIND_HEX;
    if (r < 95) return KIND_CHR;
    return KIND_NONE;
  endfunction

  task automatic test_decimal();
    send_req(KIND_DEC, 32'd0, 6'd0, 1'b0, 1'b0);
    send_req(KIND_DEC, 32'd1, 6'd0, 1'b0, 1'b0);
    send_req(KIND_DEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
    send_req(KIND_DEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 1'b0);
    // most negative value goes through its unsigned magnitude
    send_req(KIND_DEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0);
    // zeros come before the minus sign
    send_req(KIND_DEC, 32'd0 - 32'd5, 6'd4, 1'b1, 1'b0);
    send_req(KIND_DEC, 32'd12345, 6'd8, 1'b0, 1'b1);
    end_burst();
  endtask

  task automatic test_hex();
    send_req(KIND_HEX, 32'd0, 6'd0, 1'b0, 1'b0);
    send_req(KIND_HEX, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
    send_req(KIND_HEX, 32'hABCD_EF01, 6'd10, 1'b0, 1'b0);
    send_req(KIND_HEX, 32'h10, 6'd8, 1'b1, 1'b0);
    // width below the text length adds nothing and cuts nothing
    send_req(KIND_HEX, 32'h1234_5678, 6'd2, 1'b1, 1'b0);
    end_burst();
  endtask

  task automatic test_char();
    send_req(KIND_CHR, 32'hFFFF_FF00, 6'd0, 1'b0, 1'b0);
    send_req(KIND_CHR, 32'h0000_00FF, 6'd3, 1'b1, 1'b0);
    send_req(KIND_CHR, 32'h41, 6'd32, 1'b0, 1'b1);
    send_req(KIND_CHR, 32'h7A, 6'd5, 1'b0, 1'b0);
    end_burst();
  endtask

  task automatic test_padding_rules();
    // width above the cap saturates
    send_req(KIND_DEC, 32'd42, 6'd63, 1'b1, 1'b0);
    send_req(KIND_HEX, 32'hBEEF, 6'd33, 1'b0, 1'b1);
    // zero_pad has no effect on trailing pad
    send_req(KIND_DEC, 32'd0 - 32'd77, 6'd32, 1'b1, 1'b1);
    send_req(KIND_DEC, 32'd9, 6'd1, 1'b1, 1'b0);
    send_req(KIND_HEX, 32'hC, 6'd32, 1'b1, 1'b0);
    end_burst();
  endtask

  task automatic test_ignored_kind();
    send_req(KIND_NONE, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1);
    send_req(KIND_DEC, 32'd3, 6'd2, 1'b0, 1'b0);
    send_req(KIND_NONE, 32'd0, 6'd0, 1'b0, 1'b0);
    end_burst();
  endtask

  task automatic test_random_fields(input int n_items);
    for (int i = 0; i < n_items; i++)
      send_req(pick_kind(), pick_value(), pick_width(), 1'($urandom()), 1'($urandom()));
    end_burst();
  endtask

  task automatic test_back_to_back();
    no_idle <= 1'b1;
    @(posedge clk);
    test_random_fields(20);
    no_idle <= 1'b0;
    @(posedge clk);
  endtask

  // Stall the output while full-width fields keep arriving
  task automatic test_output_backpressure();
    no_idle <= 1'b1;
    hold_req <= hold_req + 1;
    @(posedge clk);
    for (int i = 0; i < 16; i++)
      send_req(pick_kind(), pick_value(), 6'd32, 1'($urandom()), 1'($urandom()));
    end_burst();
    no_idle <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random ready, always ready in no-idle runs, and the long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each character with the oldest expectation
  always @(posedge clk) begin
    fmt_char_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        err_cnt = err_cnt + 1;
      end else begin
        e = exp_chars.pop_front();
        if (out_tdata !== e.ch) begin
          $display("%0t: char mismatch, expected %h, actual %h", $time, e.ch, out_tdata);
          err_cnt = err_cnt + 1;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: tlast mismatch, expected %b, actual %b", $time, e.last, out_tlast);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_decimal();
    test_hex();
    test_char();
    test_padding_rules();
    test_ignored_kind();
    test_random_fields(50);
    test_back_to_back();
    test_output_backpressure();
    // drain the remaining characters, then watch for strays
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && exp_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
